// ----- rtl/olid_pkg.sv -----
package olid_pkg;

   localparam int MaxNodesDefault = 32;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      REQ_CREATE  = 2'd0,
      REQ_INSERT  = 2'd1,
      REQ_DELETE  = 2'd2,
      REQ_DISPLAY = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_code_type;

   typedef struct packed {
      req_code_type op;
      logic [31:0]  item;
      logic [31:0]  key;
   } cmd_type;

endpackage

// ----- rtl/olid_front.sv -----
module olid_front
   import olid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_item_value,
   input  logic [31:0] req_target_value,
   output logic        cmd_valid,
   input  logic        cmd_take,
   output cmd_type     cmd
);

   localparam int PtrW = $clog2(QueueDepth);

   cmd_type             queue_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]       count_ff, count_in;
   logic                push, pop;
   cmd_type             cmd_new;

   // delete searches on the item itself, insert on the target
   always_comb begin
      cmd_new.op   = req_code_type'(req_type);
      cmd_new.item = req_item_value;
      cmd_new.key  = (req_code_type'(req_type) == REQ_DELETE) ? req_item_value
                                                              : req_target_value;
   end

   assign req_stall = (count_ff == (PtrW+1)'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrW+1)'(QueueDepth))
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !pop)
      else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/olid_back.sv -----
module olid_back
   import olid_pkg::*;
#(
   parameter int MAX_NODES = MaxNodesDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_take,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_value,
   output logic        rsp_has_value,
   output logic        rsp_last
);

   localparam int IdxW = $clog2(MAX_NODES);
   localparam int LnkW = $clog2(MAX_NODES + 1);
   localparam logic [LnkW-1:0] NullLink = LnkW'(MAX_NODES);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_READ   = 9'b000000010,
      S_CHECK  = 9'b000000100,
      S_LINK1  = 9'b000001000,
      S_LINK2  = 9'b000010000,
      S_DISP   = 9'b000100000,
      S_DSHOW  = 9'b001000000,
      S_RESULT = 9'b010000000,
      S_WAIT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]     vals_mem [MAX_NODES];
   logic [LnkW-1:0] next_mem [MAX_NODES];
   logic [LnkW-1:0] prev_mem [MAX_NODES];

   logic [MAX_NODES-1:0] free_ff, free_in;
   logic [LnkW-1:0]      head_ff, head_in;
   cmd_type              cmd_ff, cmd_in;
   logic [LnkW-1:0]      cur_ff, cur_in;
   logic [LnkW:0]        steps_ff, steps_in;
   logic [LnkW-1:0]      tgt_ff, tgt_in;
   logic [LnkW-1:0]      alloc_ff, alloc_in;
   logic [1:0]           res_status_ff, res_status_in;

   logic [31:0]     rd_val_ff;
   logic [LnkW-1:0] rd_next_ff, rd_prev_ff;

   logic            out_valid_ff, out_valid_in;
   logic [1:0]      out_status_ff, out_status_in;
   logic [31:0]     out_value_ff, out_value_in;
   logic            out_has_ff, out_has_in;
   logic            out_last_ff, out_last_in;

   logic            rd_en;
   logic [IdxW-1:0] rd_addr;

   logic            wv_en;
   logic [IdxW-1:0] wv_addr;
   logic [31:0]     wv_data;
   logic            wn_en;
   logic [IdxW-1:0] wn_addr;
   logic [LnkW-1:0] wn_data;
   logic            wp_en;
   logic [IdxW-1:0] wp_addr;
   logic [LnkW-1:0] wp_data;

   logic [LnkW-1:0] first_free;
   logic            out_free;

   // lowest free entry, priority pick over the free map
   always_comb begin
      first_free = NullLink;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            first_free = LnkW'(i);
         end
      end
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign cmd_take  = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      head_in       = head_ff;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      tgt_in        = tgt_ff;
      alloc_in      = alloc_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_has_in    = out_has_ff;
      out_last_in   = out_last_ff;
      rd_en   = 1'b0;
      rd_addr = cur_ff[IdxW-1:0];
      wv_en   = 1'b0;
      wv_addr = alloc_ff[IdxW-1:0];
      wv_data = cmd_ff.item;
      wn_en   = 1'b0;
      wn_addr = alloc_ff[IdxW-1:0];
      wn_data = tgt_ff;
      wp_en   = 1'b0;
      wp_addr = alloc_ff[IdxW-1:0];
      wp_data = rd_prev_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               cur_in   = head_ff;
               steps_in = '0;
               unique case (cmd.op)
                  REQ_CREATE: begin
                     free_in           = '1;
                     free_in[0]        = 1'b0;
                     head_in           = '0;
                     alloc_in          = '0;
                     wv_en   = 1'b1; wv_addr = '0; wv_data = cmd.item;
                     wn_en   = 1'b1; wn_addr = '0; wn_data = NullLink;
                     wp_en   = 1'b1; wp_addr = '0; wp_data = NullLink;
                     res_status_in     = ST_OK;
                     state_in          = S_RESULT;
                  end
                  REQ_DISPLAY: begin
                     if (head_ff == NullLink) begin
                        res_status_in = ST_OK;
                        state_in      = S_RESULT;
                     end else begin
                        state_in = S_DISP;
                     end
                  end
                  default: begin
                     if (head_ff == NullLink) begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = S_RESULT;
                     end else begin
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (rd_val_ff == cmd_ff.key) begin
               tgt_in = cur_ff;
               if (cmd_ff.op == REQ_INSERT) begin
                  if (first_free == NullLink) begin
                     res_status_in = ST_FULL;
                     state_in      = S_RESULT;
                  end else begin
                     alloc_in = first_free;
                     free_in[first_free[IdxW-1:0]] = 1'b0;
                     state_in = S_LINK1;
                  end
               end else begin
                  state_in = S_LINK1;
               end
            end else if (rd_next_ff == NullLink
                         || steps_ff == (LnkW+1)'(MAX_NODES - 1)) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_RESULT;
            end else begin
               cur_in   = rd_next_ff;
               steps_in = steps_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_LINK1: begin
            if (cmd_ff.op == REQ_INSERT) begin
               // new node between prev and target
               wv_en = 1'b1;
               wn_en = 1'b1; wn_data = tgt_ff;
               wp_en = 1'b1; wp_data = rd_prev_ff;
               if (rd_prev_ff != NullLink) begin
                  state_in = S_LINK2;
               end else begin
                  head_in  = alloc_ff;
                  state_in = S_LINK2;
               end
            end else begin
               // node freed on the same edge that unlinks it, moving the head off it if it was first
               free_in[tgt_ff[IdxW-1:0]] = 1'b1;
               if (rd_prev_ff != NullLink) begin
                  wn_en = 1'b1; wn_addr = rd_prev_ff[IdxW-1:0]; wn_data = rd_next_ff;
               end else begin
                  head_in = rd_next_ff;
               end
               if (rd_next_ff != NullLink) begin
                  wp_en = 1'b1; wp_addr = rd_next_ff[IdxW-1:0]; wp_data = rd_prev_ff;
               end
               res_status_in = ST_OK;
               state_in      = S_RESULT;
            end
         end
         S_LINK2: begin
            if (rd_prev_ff != NullLink) begin
               wn_en = 1'b1; wn_addr = rd_prev_ff[IdxW-1:0]; wn_data = alloc_ff;
            end
            wp_en = 1'b1; wp_addr = tgt_ff[IdxW-1:0]; wp_data = alloc_ff;
            res_status_in = ST_OK;
            state_in      = S_RESULT;
         end
         S_DISP: begin
            rd_en    = 1'b1;
            state_in = S_DSHOW;
         end
         S_DSHOW: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = ST_OK;
               out_value_in  = rd_val_ff;
               out_has_in    = 1'b1;
               out_last_in   = (rd_next_ff == NullLink)
                               || (steps_ff == (LnkW+1)'(MAX_NODES - 1));
               if (out_last_in) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in   = rd_next_ff;
                  steps_in = steps_ff + 1'b1;
                  state_in = S_DISP;
               end
            end
         end
         S_RESULT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_value_in  = '0;
               out_has_in    = 1'b0;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_WAIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_val_ff  <= vals_mem[rd_addr];
         rd_next_ff <= next_mem[rd_addr];
         rd_prev_ff <= prev_mem[rd_addr];
      end
      if (wv_en) begin
         vals_mem[wv_addr] <= wv_data;
      end
      if (wn_en) begin
         next_mem[wn_addr] <= wn_data;
      end
      if (wp_en) begin
         prev_mem[wp_addr] <= wp_data;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      tgt_ff        <= tgt_in;
      alloc_ff      <= alloc_in;
      res_status_ff <= res_status_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_has_ff    <= out_has_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_ff      <= '1;
         head_ff      <= NullLink;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         head_ff      <= head_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_has_value = out_has_ff;
   assign rsp_last      = out_last_ff;

`ifndef SYNTHESIS
   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");
   a_head_used: assert property (@(posedge clock) disable iff (reset)
      (head_ff != NullLink) |-> !free_ff[head_ff[IdxW-1:0]])
      else $error("head points at a free node");
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_value) |-> (rsp_out_value == '0 && rsp_last))
      else $error("non-display result malformed");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DSHOW) |-> !cmd_take)
      else $error("command taken mid display");
`endif

endmodule

// ----- rtl/ordered_list_insert_delete.sv -----
// Create goes from idle straight to the result; insert/delete do a registered node
// read and a compare per node walked, then the link states and the result.
// Display: a registered node read, then the element is shown, for each node.
// One item at a time in the back end; a two-entry queue accepts items until full.
// Reset (synchronous): list empty, all nodes free, queue and result valid cleared.
module ordered_list_insert_delete
   import olid_pkg::*;
#(
   parameter int MAX_NODES = MaxNodesDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_item_value,
   input  logic [31:0] req_target_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_value,
   output logic        rsp_has_value,
   output logic        rsp_last
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   olid_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_item_value   (req_item_value),
      .req_target_value (req_target_value),
      .cmd_valid        (cmd_valid),
      .cmd_take         (cmd_take),
      .cmd              (cmd)
   );

   olid_back #(.MAX_NODES(MAX_NODES)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_take      (cmd_take),
      .cmd           (cmd),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_has_value (rsp_has_value),
      .rsp_last      (rsp_last)
   );

endmodule
